/* rtl/core/pll_rate_decoder_unit_macros.svh */
// ---------------------------------------------------------------------------
// PLL rate decoder assertion macros
// Clocked on clock, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PLL_RATE_DECODER_UNIT_MACROS_SVH
`define PLL_RATE_DECODER_UNIT_MACROS_SVH

// consequent holds in the same cycle
`define PRD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/prd_pkg.sv */
// ---------------------------------------------------------------------------
// prd_pkg
// Types and constants shared by the PLL rate decoder pipeline.
// ---------------------------------------------------------------------------
package prd_pkg;

   localparam int PARENT_W   = 32;
   localparam int RATE_W     = 40;
   localparam int MULT_W     = 9;
   localparam int DIV_W      = 6;
   localparam int REM_W      = 5;
   localparam int CHUNK_W    = 8;
   localparam int DIV_STAGES = RATE_W / CHUNK_W;

   localparam logic [PARENT_W-1:0] PARENT_RESET  = 32'd24000000;
   localparam logic [RATE_W-1:0]   FIXED_RATE_HI = 40'd297000000;
   localparam logic [RATE_W-1:0]   FIXED_RATE_LO = 40'd270000000;

   typedef enum logic [2:0] {
      PLL_CPU    = 3'd0,
      PLL_AUDIO  = 3'd1,
      PLL_VIDEO  = 3'd2,
      PLL_VE     = 3'd3,
      PLL_DDR    = 3'd4,
      PLL_PERIPH = 3'd5
   } prd_func_type;

   typedef struct packed {
      logic [MULT_W-1:0] mult;
      logic [DIV_W-1:0]  divisor;
      logic              fixed;
      logic              fixed_hi;
   } prd_dec_type;

   typedef struct packed {
      logic [RATE_W-1:0] work;
      logic [REM_W-1:0]  rem;
      logic [DIV_W-1:0]  divisor;
   } prd_div_type;

endpackage

/* rtl/core/pll_rate_decoder_unit.sv */
// ---------------------------------------------------------------------------
// pll_rate_decoder_unit
// PLL output frequency from control word and parent clock rate.
//
//   Port group   Dir   Handshake            Word
//   req_         in    req_valid/req_stall  req_func, req_ctrl_word
//   rsp_         out   rsp_valid/rsp_stall  rsp_rate_hz
//   csr_         in    csr_wr_en            csr_wr_data (parent rate, Hz)
//
// Stages: decode, multiply, five divide stages of 8 quotient bits.
// One word per cycle sustained while rsp_stall is low; every stage has its own valid bit.
// Bubbles collapse: a stalled result backs up only the full stages behind it.
// Synchronous reset clears valid bits; parent rate resets to 24 MHz.
// ---------------------------------------------------------------------------
`include "pll_rate_decoder_unit_macros.svh"

module pll_rate_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_ctrl_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [39:0] rsp_rate_hz,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int NS = prd_pkg::DIV_STAGES;

   logic [31:0]          parent_rate_ff;
   logic [31:0]          parent_rate_in;
   logic                 dec_valid;
   logic                 dec_stall;
   prd_pkg::prd_dec_type dec_data;
   logic                 dv_valid [0:NS];
   logic                 dv_stall [0:NS];
   prd_pkg::prd_div_type dv_data  [0:NS];

   assign parent_rate_in = csr_wr_en ? csr_wr_data : parent_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         parent_rate_ff <= prd_pkg::PARENT_RESET;
      end else begin
         parent_rate_ff <= parent_rate_in;
      end
   end

   prd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_func      (req_func),
      .in_ctrl_word (req_ctrl_word),
      .out_valid    (dec_valid),
      .out_stall    (dec_stall),
      .out_data     (dec_data)
   );

   prd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .parent_rate (parent_rate_ff),
      .in_valid    (dec_valid),
      .in_stall    (dec_stall),
      .in_data     (dec_data),
      .out_valid   (dv_valid[0]),
      .out_stall   (dv_stall[0]),
      .out_data    (dv_data[0])
   );

   for (genvar g = 0; g < NS; g++) begin : g_div
      prd_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[g]),
         .in_stall  (dv_stall[g]),
         .in_data   (dv_data[g]),
         .out_valid (dv_valid[g+1]),
         .out_stall (dv_stall[g+1]),
         .out_data  (dv_data[g+1])
      );
   end

   assign dv_stall[NS] = rsp_stall;
   assign rsp_valid    = dv_valid[NS];
   assign rsp_rate_hz  = dv_data[NS].work;

   `PRD_ASSERT_NEXT(a_req_enters_decode, req_valid && !req_stall, dec_valid, "word lost")
   `PRD_ASSERT_NEXT(a_dec_enters_scale, dec_valid && !dec_stall, dv_valid[0], "word lost")
   `PRD_ASSERT_NOW(a_scale_rem_clear, dv_valid[0], dv_data[0].rem == '0, "rem not clear")
   `PRD_ASSERT_NOW(a_rem_below_div, rsp_valid, dv_data[NS].rem < dv_data[NS].divisor, "bad rem")

endmodule

/* rtl/core/prd_decode.sv */
// ---------------------------------------------------------------------------
// prd_decode
// Control word field decode: multiplier, divisor and fixed-rate select.
// ---------------------------------------------------------------------------
module prd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [2:0]           in_func,
   input  logic [31:0]          in_ctrl_word,
   output logic                 out_valid,
   input  logic                 out_stall,
   output prd_pkg::prd_dec_type out_data
);

   // x * (k + 1) for k in 0..3, shift-add
   function automatic logic [8:0] times_k1(input logic [6:0] x, input logic [1:0] k);
      logic [8:0] xw;
      xw = {2'b00, x};
      case (k)
         2'd0:    times_k1 = xw;
         2'd1:    times_k1 = xw << 1;
         2'd2:    times_k1 = xw + (xw << 1);
         2'd3:    times_k1 = xw << 2;
         default: times_k1 = xw;
      endcase
   endfunction

   logic                 valid_ff;
   logic                 valid_in;
   prd_pkg::prd_dec_type data_ff;
   prd_pkg::prd_dec_type data_in;
   logic                 take;
   logic [5:0]           n_five;
   logic [2:0]           m_one;
   logic [2:0]           p_one;
   logic [8:0]           nk;
   logic [5:0]           mp;
   logic [7:0]           n_audio;
   logic [7:0]           n_video;

   assign take     = !valid_ff || !out_stall;
   assign in_stall = !take;
   assign valid_in = in_valid;

   always_comb begin
      n_five  = {1'b0, in_ctrl_word[12:8]} + 6'd1;
      m_one   = {1'b0, in_ctrl_word[1:0]} + 3'd1;
      p_one   = {1'b0, in_ctrl_word[17:16]} + 3'd1;
      nk      = times_k1({1'b0, n_five}, in_ctrl_word[5:4]);
      mp      = 6'(times_k1({4'b0000, m_one}, in_ctrl_word[17:16]));
      n_audio = in_ctrl_word[24] ? ({4'b0000, in_ctrl_word[11:8]} + 8'd1)
                                 : ({1'b0, in_ctrl_word[14:8]} + 8'd1);
      n_video = {1'b0, in_ctrl_word[14:8]} + 8'd1;

      data_in = '{mult: '0, divisor: 6'd1, fixed: 1'b0, fixed_hi: 1'b0};
      case (prd_pkg::prd_func_type'(in_func))
         prd_pkg::PLL_CPU: begin
            data_in.mult    = nk;
            data_in.divisor = mp;
         end
         prd_pkg::PLL_AUDIO: begin
            data_in.mult    = {n_audio, 1'b0};
            data_in.divisor = {1'b0, in_ctrl_word[4:0]} + 6'd1;
         end
         prd_pkg::PLL_VIDEO, prd_pkg::PLL_VE: begin
            if (in_ctrl_word[24]) begin
               data_in.mult    = {1'b0, n_video};
               data_in.divisor = {2'b00, in_ctrl_word[3:0]} + 6'd1;
            end else begin
               data_in.fixed    = 1'b1;
               data_in.fixed_hi = in_ctrl_word[25];
            end
         end
         prd_pkg::PLL_DDR: begin
            data_in.mult    = nk;
            data_in.divisor = {3'b000, m_one};
         end
         prd_pkg::PLL_PERIPH: begin
            data_in.mult    = nk;
            data_in.divisor = {3'b000, p_one};
         end
         default: begin
            data_in.mult    = '0;
            data_in.divisor = 6'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= valid_in;
      end
      if (take && valid_in) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/prd_scale.sv */
// ---------------------------------------------------------------------------
// prd_scale
// Parent rate times multiplier, or the fixed video rate, as the dividend.
// ---------------------------------------------------------------------------
module prd_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          parent_rate,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  prd_pkg::prd_dec_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output prd_pkg::prd_div_type out_data
);

   logic                 valid_ff;
   prd_pkg::prd_div_type data_ff;
   prd_pkg::prd_div_type data_in;
   logic                 take;
   logic [39:0]          prod;

   assign take     = !valid_ff || !out_stall;
   assign in_stall = !take;

   always_comb begin
      prod = parent_rate * in_data.mult;
      data_in.rem     = '0;
      data_in.divisor = in_data.divisor;
      if (in_data.fixed) begin
         data_in.work = in_data.fixed_hi ? prd_pkg::FIXED_RATE_HI : prd_pkg::FIXED_RATE_LO;
      end else begin
         data_in.work = prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
      if (take && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/prd_div_stage.sv */
// ---------------------------------------------------------------------------
// prd_div_stage
// One restoring-division stage: eight quotient bits per pass.
// Work word shifts left; quotient bits fill in from the bottom.
// ---------------------------------------------------------------------------
module prd_div_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  prd_pkg::prd_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output prd_pkg::prd_div_type out_data
);

   localparam int RW = prd_pkg::RATE_W;
   localparam int CW = prd_pkg::CHUNK_W;

   logic                          valid_ff;
   prd_pkg::prd_div_type          data_ff;
   prd_pkg::prd_div_type          data_in;
   logic                          take;
   logic [prd_pkg::REM_W-1:0]     r;
   logic [prd_pkg::DIV_W-1:0]     t;
   logic [CW-1:0]                 q;

   assign take     = !valid_ff || !out_stall;
   assign in_stall = !take;

   always_comb begin
      r = in_data.rem;
      q = '0;
      t = '0;
      for (int i = 0; i < CW; i++) begin
         t = {r, in_data.work[RW-1-i]};
         if (t >= in_data.divisor) begin
            r           = prd_pkg::REM_W'(t - in_data.divisor);
            q[CW-1-i]   = 1'b1;
         end else begin
            r = t[prd_pkg::REM_W-1:0];
         end
      end
      data_in.work    = {in_data.work[RW-CW-1:0], q};
      data_in.rem     = r;
      data_in.divisor = in_data.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
      if (take && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* tb/tb_pll_rate_decoder_unit.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pll_rate_decoder_unit
// Checks PLL rate words against a behavioral rate calculator. Directed
// corner words go first, then random words under several parent rates.
// Both channels idle at random, the result side holds off long enough to
// back the pipeline up, and the run ends with a quiet stretch.
// ---------------------------------------------------------------------------
module tb_pll_rate_decoder_unit;

   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 9;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_LIMIT      = 2000;
   localparam int SETTLE_CYCLES    = 20;
   localparam int LONG_HOLD_CYCLES = 40;
   localparam int PHASE_WORDS      = 100;
   localparam int NUM_PHASES       = 6;

   localparam logic [2:0] FUNC_BAD_A = 3'd6;
   localparam logic [2:0] FUNC_BAD_B = 3'd7;
   localparam logic [2:0] ALL_FUNCS [8] = '{prd_pkg::PLL_CPU, prd_pkg::PLL_AUDIO,
                                            prd_pkg::PLL_VIDEO, prd_pkg::PLL_VE,
                                            prd_pkg::PLL_DDR, prd_pkg::PLL_PERIPH,
                                            FUNC_BAD_A, FUNC_BAD_B};

   class rate_scoreboard;
      logic [prd_pkg::PARENT_W-1:0] parent_rate;
      logic [prd_pkg::RATE_W-1:0]   rate_q[$];
      int                           errors;

      function new();
         parent_rate = prd_pkg::PARENT_RESET;
         errors      = 0;
      endfunction

      function logic [prd_pkg::RATE_W-1:0] calc_rate(logic [2:0] f, logic [31:0] w);
         logic [63:0] par;
         logic [63:0] n;
         logic [63:0] k;
         logic [63:0] m;
         logic [63:0] p;
         logic [63:0] r;
         par = 64'(parent_rate);
         n   = 64'(w[12:8]) + 64'd1;
         k   = 64'(w[5:4]) + 64'd1;
         m   = 64'(w[1:0]) + 64'd1;
         p   = 64'(w[17:16]) + 64'd1;
         case (f)
            prd_pkg::PLL_CPU:    r = (par * n * k) / (m * p);
            prd_pkg::PLL_AUDIO: begin
               n = w[24] ? 64'(w[11:8]) + 64'd1 : 64'(w[14:8]) + 64'd1;
               m = 64'(w[4:0]) + 64'd1;
               r = (par * n * 64'd2) / m;
            end
            prd_pkg::PLL_VIDEO, prd_pkg::PLL_VE: begin
               if (w[24]) begin
                  r = (par * (64'(w[14:8]) + 64'd1)) / (64'(w[3:0]) + 64'd1);
               end else begin
                  r = w[25] ? 64'(prd_pkg::FIXED_RATE_HI) : 64'(prd_pkg::FIXED_RATE_LO);
               end
            end
            prd_pkg::PLL_DDR:    r = (par * n * k) / m;
            prd_pkg::PLL_PERIPH: r = (par * n * k) / p;
            default:             r = 64'd0;
         endcase
         return r[prd_pkg::RATE_W-1:0];
      endfunction

      function void note_query(logic [2:0] f, logic [31:0] w);
         rate_q.push_back(calc_rate(f, w));
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_rate(logic [prd_pkg::RATE_W-1:0] got);
         logic [prd_pkg::RATE_W-1:0] want;
         if (rate_q.size() == 0) begin
            report($sformatf("unexpected result word, rate_hz=%0d", got));
         end else begin
            want = rate_q.pop_front();
            if (got !== want)
               report($sformatf("rate_hz got %0d, want %0d", got, want));
         end
      endtask

      task flush_leftovers();
         while (rate_q.size() != 0)
            report($sformatf("missing result word, rate_hz=%0d", rate_q.pop_front()));
      endtask

      function int pending();
         return rate_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_func;
   logic [31:0] req_ctrl_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [39:0] rsp_rate_hz;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   rate_scoreboard sb = new();
   bit             idle_en;
   int             hold_cycles;
   int             cycle_count;

   pll_rate_decoder_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_ctrl_word (req_ctrl_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rate_hz   (rsp_rate_hz),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stall bursts, plus long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_rate(rsp_rate_hz);
   end

   // entered and left at a falling edge
   task send_word(input logic [2:0] f, input logic [31:0] w, input bit allow_gap);
      if (idle_en && allow_gap && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_func      = f;
      req_ctrl_word = w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_query(f, w);
      @(negedge clock);
   endtask

   task drain_results();
      int waited;
      req_valid = 1'b0;
      waited    = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_parent_rate(input logic [31:0] rate);
      drain_results();
      csr_wr_en   = 1'b1;
      csr_wr_data = rate;
      @(posedge clock);
      sb.parent_rate = rate;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      logic [31:0] phase_rates [NUM_PHASES];
      logic [2:0]  f;
      bit          gap_ok;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = prd_pkg::PLL_CPU;
      req_ctrl_word = 32'h0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 32'h0;
      idle_en       = 1'b0;
      hold_cycles   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners at the reset parent rate
      foreach (ALL_FUNCS[i]) begin
         send_word(ALL_FUNCS[i], 32'h0000_0000, 1'b0);
         send_word(ALL_FUNCS[i], 32'hFFFF_FFFF, 1'b0);
      end
      send_word(prd_pkg::PLL_VIDEO, 32'h0200_0000, 1'b0);
      send_word(prd_pkg::PLL_VE, 32'h0200_0000, 1'b0);
      send_word(prd_pkg::PLL_VIDEO, 32'h0100_7F00, 1'b0);
      send_word(prd_pkg::PLL_AUDIO, 32'h0100_7F1F, 1'b0);
      send_word(prd_pkg::PLL_AUDIO, 32'h0000_7F00, 1'b0);
      send_word(prd_pkg::PLL_CPU, 32'h0000_1F30, 1'b0);

      phase_rates = '{$urandom, 32'h0, 32'hFFFF_FFFF, 32'h1, prd_pkg::PARENT_RESET,
                      $urandom};
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_parent_rate(phase_rates[ph]);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            idle_en = (ph != NUM_PHASES - 1) && !(i >= 40 && i < 60);
            if (ph == 2 && i == 50)
               hold_cycles = LONG_HOLD_CYCLES;
            gap_ok = !(ph == 2 && i >= 50 && i < 80);
            f = ($urandom_range(0, 9) == 0) ? ALL_FUNCS[$urandom_range(6, 7)]
                                            : ALL_FUNCS[$urandom_range(0, 5)];
            send_word(f, $urandom, gap_ok);
         end
      end

      idle_en = 1'b0;
      drain_results();
      sb.flush_leftovers();
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
